// ----- rtl/shamh_pkg.sv -----
package shamh_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned Words  = 8;
	localparam int unsigned Rounds = 64;

	typedef logic [WordW-1:0] word_t;
	typedef logic [5:0]       round_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PREP  = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_ADD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	localparam logic [7:0] PadByte = 8'h80;

	localparam word_t InitHash [Words] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t rotr(input word_t v, input int unsigned n);
		rotr = (v >> n) | (v << (WordW - n));
	endfunction

	function automatic word_t round_k(input round_t r);
		case (r)
			6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h0;
		endcase
	endfunction

endpackage

// ----- rtl/shamh_if.sv -----
interface shamh_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface shamh_dig_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [1:0]  word_index;
	logic        final_word;

	modport source (output valid, digest_word, word_index, final_word, input ready);
	modport sink   (input valid, digest_word, word_index, final_word, output ready);
endinterface

// ----- rtl/sha256_message_hasher.sv -----
// Channel | Dir | Request content
// msg     | in  | data_byte, byte_present, end_of_message
// dig     | out | digest_word, word_index, final_word (four requests per message)
//
// The 64th byte of a block starts a compression: a load step (ST_PREP), 64 rounds at one round
// per cycle, and a chaining add (ST_ADD).
// An ending request runs one or two compressions, then hands out four digest requests.
// The block buffer is a 16 x 32-bit memory read one word per round over the first 16 rounds;
// msg waits while a block is compressed.
// Reset loads the initial hash and clears counters; the buffer itself is not cleared.
// A stall on dig holds the current digest word and keeps msg closed.
module sha256_message_hasher
	import shamh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	shamh_msg_if.sink   msg,
	shamh_dig_if.source dig
);

	state_t      state_q;
	word_t       chain_q [Words];
	word_t       wv_q    [Words];
	word_t       wsr_q   [16];
	word_t       buf_mem [16];
	word_t       rd_q;
	logic [3:0]  rd_addr;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	round_t      rnd_q;
	logic [6:0]  lim_q;
	logic        pad_q;
	logic        len_q;
	logic        fin_q;
	logic [1:0]  idx_q;

	logic        msg_acc;
	logic        dig_acc;
	logic [5:0]  fill_nx;
	word_t       w_cur, w_sched, w_load;
	word_t       t1, t2, ls0, ls1;

	assign msg_acc = msg.valid && msg.ready;
	assign dig_acc = dig.valid && dig.ready;
	assign msg.ready = (state_q == ST_IDLE);
	assign fill_nx = fill_q + 6'(msg.byte_present);

	// pick the padded byte for block position b from the raw buffer byte
	function automatic logic [7:0] pad_byte(input logic [5:0] b, input logic [7:0] raw,
		input logic [6:0] lim, input logic pad, input logic len, input logic [63:0] bits);
		logic [63:0] sh;
		sh = bits >> {~b[2:0], 3'b000};
		if ({1'b0, b} < lim)
			pad_byte = raw;
		else if (pad && ({1'b0, b} == lim))
			pad_byte = PadByte;
		else if (len && (b >= 6'd56))
			pad_byte = sh[7:0];
		else
			pad_byte = 8'h00;
	endfunction

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			w_load[8*(3-i) +: 8] = pad_byte({rnd_q[3:0], 2'(i)}, rd_q[8*(3-i) +: 8],
				lim_q, pad_q, len_q, bits_q);
		end
	end

	// message schedule from the sixteen-word shift line
	assign ls0 = rotr(wsr_q[1], 7) ^ rotr(wsr_q[1], 18) ^ (wsr_q[1] >> 3);
	assign ls1 = rotr(wsr_q[14], 17) ^ rotr(wsr_q[14], 19) ^ (wsr_q[14] >> 10);
	assign w_sched = ls1 + wsr_q[9] + ls0 + wsr_q[0];
	assign w_cur = (rnd_q < 6'd16) ? w_load : w_sched;

	// one compression round
	assign t1 = wv_q[7] + (rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25))
		+ ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6])) + round_k(rnd_q) + w_cur;
	assign t2 = (rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22))
		+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

	assign rd_addr = (state_q == ST_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;

	// block buffer: byte writes, one registered word read
	always_ff @(posedge clk) begin
		if (msg_acc && msg.byte_present)
			buf_mem[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= msg.data_byte;
		rd_q <= buf_mem[rd_addr];
	end

	// working variables and schedule shift line
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			for (int i = 0; i < Words; i++)
				wv_q[i] <= chain_q[i];
		end else if (state_q == ST_ROUND) begin
			wv_q[0] <= t1 + t2;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= wv_q[1];
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[5] <= wv_q[4];
			wv_q[6] <= wv_q[5];
			wv_q[7] <= wv_q[6];
			for (int i = 0; i < 15; i++)
				wsr_q[i] <= wsr_q[i+1];
			wsr_q[15] <= w_cur;
		end
	end

	// sequencer, counters and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < Words; i++)
				chain_q[i] <= InitHash[i];
			fill_q <= '0;
			bits_q <= '0;
			rnd_q  <= '0;
			lim_q  <= '0;
			pad_q  <= 1'b0;
			len_q  <= 1'b0;
			fin_q  <= 1'b0;
			idx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						fill_q <= fill_nx;
						if (msg.byte_present)
							bits_q <= bits_q + 64'd8;
						fin_q <= msg.end_of_message;
						if (msg.byte_present && (fill_q == 6'd63)) begin
							lim_q   <= 7'd64;
							pad_q   <= 1'b0;
							len_q   <= 1'b0;
							state_q <= ST_PREP;
						end else if (msg.end_of_message) begin
							lim_q   <= {1'b0, fill_nx};
							pad_q   <= 1'b1;
							len_q   <= (fill_nx <= 6'd55);
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(Rounds - 1))
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < Words; i++)
						chain_q[i] <= chain_q[i] + wv_q[i];
					if (len_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (fin_q) begin
						pad_q   <= (lim_q == 7'd64);
						lim_q   <= '0;
						len_q   <= 1'b1;
						state_q <= ST_PREP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig_acc) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							for (int i = 0; i < Words; i++)
								chain_q[i] <= InitHash[i];
							fill_q  <= '0;
							bits_q  <= '0;
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// digest words straight from the chaining registers
	assign dig.valid       = (state_q == ST_OUT);
	assign dig.word_index  = idx_q;
	assign dig.final_word  = (idx_q == 2'd3);
	assign dig.digest_word = {chain_q[{idx_q, 1'b0}], chain_q[{idx_q, 1'b1}]};

`ifndef SYNTHESIS
	a_clear_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		dig_acc && dig.final_word |=> (fill_q == 6'd0) && (bits_q == 64'd0))
		else $error("state not cleared after last digest word");
	a_rounds_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (rnd_q == 6'd63) |=> (state_q == ST_ADD))
		else $error("compression did not end after the last round");
	a_no_input_in_output: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> !msg.ready)
		else $error("message request taken while digest pending");
`endif

endmodule
